// ----- hdl/incremental_shannon_entropy_top_assert.svh -----
// Assertion helpers for the entropy block.
`ifndef INCREMENTAL_SHANNON_ENTROPY_TOP_ASSERT_SVH
`define INCREMENTAL_SHANNON_ENTROPY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ISE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ise_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

    // Default geometry.
    localparam int ISE_SYMBOL_BITS = 8;
    localparam int ISE_COUNT_BITS  = 32;
    localparam int ISE_FRAC_BITS   = 16;

    // Fixed widths.
    localparam int MANT_BITS  = 32;
    localparam int SUM_BITS   = 64;
    localparam int ENTROPY_W  = 20;

    // Input beat.
    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] count;
        logic        last_of_sequence;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [ENTROPY_W-1:0] entropy;
        logic                 overflow;
    } result_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_NORM,
        ST_SQUARE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    // Which value the log unit is working on.
    typedef enum logic [1:0] {
        PH_OLD,
        PH_NEW,
        PH_TOTAL
    } phase_t;

endpackage

`default_nettype wire

// ----- hdl/incremental_shannon_entropy_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Beat
// item      in         item_valid/item_stall   symbol, count, last_of_sequence
// result    out        result_valid/result_stall entropy, overflow
//
// The first item of a sequence skips the total log and the divide. The shared log unit
// (normalize, then one squaring per fraction bit) and the restoring divider, one quotient
// bit per cycle, do the work; frequencies sit in a one-port synchronous memory.
// Reset clears the valid bits, total and sum at once; no clearing pass is needed.
// A result waits in its output register while the next item is accepted and worked on.
module incremental_shannon_entropy_top #(
    parameter int SYMBOL_BITS = ise_pkg::ISE_SYMBOL_BITS,
    parameter int COUNT_BITS  = ise_pkg::ISE_COUNT_BITS,
    parameter int FRAC_BITS   = ise_pkg::ISE_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ise_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ise_pkg::result_t result
);
    import ise_pkg::*;

    localparam int NUM_SYM = 1 << SYMBOL_BITS;
    localparam int NW      = (COUNT_BITS > MANT_BITS) ? COUNT_BITS : MANT_BITS;
    localparam int KW      = $clog2(NW);
    localparam int SW      = $clog2(KW);
    localparam int LW      = KW + FRAC_BITS;
    localparam int PW      = MANT_BITS + LW;
    localparam int SUMW    = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam int CW      = $clog2(FRAC_BITS + 1);
    localparam int DCW     = $clog2(SUM_BITS + 1);
    localparam int RW      = COUNT_BITS + 1;

    state_t state_reg, state_next;
    phase_t phase_reg;

    // Frequency memory and per-entry valid bits.
    logic [COUNT_BITS-1:0] freq_mem [NUM_SYM];
    logic [NUM_SYM-1:0]    valid_reg;
    logic [COUNT_BITS-1:0] rd_reg;

    // Item and totals.
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [15:0]            cnt_reg;
    logic                   last_reg;
    logic [COUNT_BITS-1:0]  old_f_reg, new_f_reg, total_reg;
    logic                   ent_en_reg, ovf_reg;
    logic [SUM_BITS-1:0]    sum_reg;

    // Log unit.
    logic [NW-1:0]        x_reg;
    logic [KW-1:0]        k_reg;
    logic [SW-1:0]        step_reg;
    logic                 xzero_reg;
    logic [MANT_BITS-1:0] y_reg;
    logic [FRAC_BITS-1:0] bits_reg;
    logic [CW-1:0]        sq_cnt_reg;

    // Term multiply and divider.
    logic [PW-1:0]       prod_reg;
    logic [SUM_BITS-1:0] term_reg;
    logic [SUM_BITS-1:0] dvd_reg;
    logic [RW-1:0]       rem_reg;
    logic [DCW-1:0]      div_cnt_reg;

    result_t result_reg;
    logic    result_valid_reg;

    logic                  accept, load_result;
    logic [COUNT_BITS-1:0] old_f, new_f_c, new_t_c;
    logic [SUMW-1:0]       sum_f, sum_t, max_w;
    logic                  sat_f, sat_t;
    logic [KW-1:0]         sh;
    logic [NW-1:0]         shifted, norm_x;
    logic                  top_zero;
    logic [2*MANT_BITS-1:0] sq;
    logic [MANT_BITS:0]    sq_sh;
    logic [LW-1:0]         log_val;
    logic [SUM_BITS-1:0]   f_ext, term_full, ent64, q_fin;
    logic [MANT_BITS-1:0]  mul_a;
    logic [PW-1:0]         mul_p;
    logic [RW-1:0]         rem_sh, rem_next;
    logic                  ge;
    logic [ENTROPY_W-1:0]  ent20;

    // Saturating updates of the frequency and the total.
    always_comb
    begin
        old_f   = valid_reg[sym_reg] ? rd_reg : '0;
        max_w   = SUMW'({COUNT_BITS{1'b1}});
        sum_f   = SUMW'(old_f) + SUMW'(cnt_reg);
        sum_t   = SUMW'(total_reg) + SUMW'(cnt_reg);
        sat_f   = sum_f > max_w;
        sat_t   = sum_t > max_w;
        new_f_c = sat_f ? {COUNT_BITS{1'b1}} : sum_f[COUNT_BITS-1:0];
        new_t_c = sat_t ? {COUNT_BITS{1'b1}} : sum_t[COUNT_BITS-1:0];
    end

    // Log unit datapath: one normalize step or one squaring per cycle.
    always_comb
    begin
        sh       = KW'(1) << step_reg;
        shifted  = x_reg << sh;
        top_zero = (shifted >> sh) == x_reg;
        norm_x   = top_zero ? shifted : x_reg;
        sq       = (2*MANT_BITS)'(y_reg) * (2*MANT_BITS)'(y_reg);
        sq_sh    = sq[2*MANT_BITS-1:MANT_BITS-1];
        log_val  = xzero_reg ? '0 : {k_reg, bits_reg};
    end

    // Term f * log2(f), in two partial products.
    always_comb
    begin
        f_ext     = SUM_BITS'((phase_reg == PH_OLD) ? old_f_reg : new_f_reg);
        mul_a     = (state_reg == ST_MUL_LO) ? f_ext[MANT_BITS-1:0]
                                             : f_ext[SUM_BITS-1:MANT_BITS];
        mul_p     = PW'(mul_a) * PW'(log_val);
        term_full = term_reg + (SUM_BITS'(prod_reg) << MANT_BITS);
    end

    // Restoring divider step and final entropy.
    always_comb
    begin
        rem_sh   = {rem_reg[RW-2:0], dvd_reg[SUM_BITS-1]};
        ge       = rem_sh >= RW'(total_reg);
        rem_next = ge ? (rem_sh - RW'(total_reg)) : rem_sh;
        q_fin    = dvd_reg;
        ent64    = (SUM_BITS'(log_val) > q_fin) ? (SUM_BITS'(log_val) - q_fin) : '0;
        ent20    = (ent64 > SUM_BITS'({ENTROPY_W{1'b1}})) ? {ENTROPY_W{1'b1}}
                                                          : ent64[ENTROPY_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = ST_NORM;
            ST_NORM:   if (step_reg == '0) state_next = ST_SQUARE;
            ST_SQUARE:
            begin
                if (sq_cnt_reg == CW'(FRAC_BITS - 1))
                    state_next = (phase_reg == PH_TOTAL) ? ST_DIV : ST_MUL_LO;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:
            begin
                if (phase_reg == PH_OLD || ent_en_reg)
                    state_next = ST_NORM;
                else
                    state_next = ST_DONE;
            end
            ST_DIV:    if (div_cnt_reg == DCW'(SUM_BITS - 1)) state_next = ST_DONE;
            ST_DONE:   if (load_result) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        item_stall   = (state_reg != ST_IDLE);
        accept       = item_valid && !item_stall;
        load_result  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
        result_valid = result_valid_reg;
        result       = result_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            total_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                valid_reg[sym_reg] <= 1'b1;
                total_reg          <= new_t_c;
            end
            if (state_reg == ST_ACC)
                sum_reg <= (phase_reg == PH_OLD) ? (sum_reg - term_full)
                                                 : (sum_reg + term_full);
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    valid_reg <= '0;
                    total_reg <= '0;
                    sum_reg   <= '0;
                end
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Frequency memory: registered read at accept, write-back after the update.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= freq_mem[SYMBOL_BITS'(item.symbol)];
        if (state_reg == ST_READ)
            freq_mem[sym_reg] <= new_f_c;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sym_reg  <= SYMBOL_BITS'(item.symbol);
                cnt_reg  <= item.count;
                last_reg <= item.last_of_sequence;
            end
            ST_READ:
            begin
                old_f_reg  <= old_f;
                new_f_reg  <= new_f_c;
                ovf_reg    <= sat_f || sat_t;
                ent_en_reg <= (total_reg != '0) && (new_t_c != '0);
                phase_reg  <= PH_OLD;
                x_reg      <= NW'(old_f);
                xzero_reg  <= (old_f == '0);
                k_reg      <= KW'(NW - 1);
                step_reg   <= SW'(KW - 1);
            end
            ST_NORM:
            begin
                x_reg      <= norm_x;
                k_reg      <= top_zero ? (k_reg - sh) : k_reg;
                step_reg   <= step_reg - SW'(1);
                y_reg      <= norm_x[NW-1 -: MANT_BITS];
                bits_reg   <= '0;
                sq_cnt_reg <= '0;
            end
            ST_SQUARE:
            begin
                y_reg       <= sq_sh[MANT_BITS] ? sq_sh[MANT_BITS:1] : sq_sh[MANT_BITS-1:0];
                bits_reg    <= {bits_reg[FRAC_BITS-2:0], sq_sh[MANT_BITS]};
                sq_cnt_reg  <= sq_cnt_reg + CW'(1);
                dvd_reg     <= sum_reg;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_MUL_LO:
                prod_reg <= mul_p;
            ST_MUL_HI:
            begin
                term_reg <= SUM_BITS'(prod_reg);
                prod_reg <= mul_p;
            end
            ST_ACC:
            begin
                phase_reg <= (phase_reg == PH_OLD) ? PH_NEW : PH_TOTAL;
                x_reg     <= NW'((phase_reg == PH_OLD) ? new_f_reg : total_reg);
                xzero_reg <= ((phase_reg == PH_OLD) ? new_f_reg : total_reg) == '0;
                k_reg     <= KW'(NW - 1);
                step_reg  <= SW'(KW - 1);
            end
            ST_DIV:
            begin
                dvd_reg     <= {dvd_reg[SUM_BITS-2:0], ge};
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            ST_DONE:
            begin
                if (load_result)
                begin
                    result_reg.entropy  <= ent_en_reg ? ent20 : '0;
                    result_reg.overflow <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`include "incremental_shannon_entropy_top_assert.svh"

    `ISE_ASSERT_NXT(a_accept_read, accept, state_reg == ST_READ, "accepted item did not read")
    `ISE_ASSERT_IMP(a_freq_le_total, state_reg == ST_ACC, new_f_reg <= total_reg, "freq above total")
    `ISE_ASSERT_IMP(a_div_enabled, state_reg == ST_DIV, ent_en_reg, "divide on first item")
    `ISE_ASSERT_NXT(a_done_shows, load_result, result_valid, "result not presented")

endmodule

`default_nettype wire

// ----- bench/incremental_shannon_entropy_checker.sv -----
`timescale 1ns / 1ps

module incremental_shannon_entropy_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  ise_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  ise_pkg::result_t result,
    output int               error_count,
    output int               pending_count,
    output int               result_count
);
    import ise_pkg::*;

    localparam longint unsigned FREQ_MAX    = (64'd1 << ISE_COUNT_BITS) - 1;
    localparam longint unsigned ENTROPY_TOP = (64'd1 << ENTROPY_W) - 1;

    // Shadow copy of the histogram and running sums.
    longint unsigned freq_hist [0:(1 << ISE_SYMBOL_BITS) - 1];
    longint unsigned freq_total;
    longint unsigned log_sum;
    result_t         expected_results[$];

    // Fixed-point log2 with one squaring per fraction bit.
    function automatic longint unsigned log2_fixed(input longint unsigned x);
        int              msb;
        longint unsigned mant;
        longint unsigned frac;
        msb  = 0;
        frac = 0;
        if (x == 0)
            return 0;
        while (msb < 63 && (x >> (msb + 1)) != 0)
            msb++;
        mant = (msb > 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        for (int i = 0; i < ISE_FRAC_BITS; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd2 << 31))
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return (longint'(msb) << ISE_FRAC_BITS) | frac;
    endfunction

    // Apply one item to the shadow histogram and return its entropy beat.
    function automatic result_t entropy_after_item(input item_t it);
        longint unsigned old_f;
        longint unsigned new_f;
        longint unsigned prev_total;
        longint unsigned new_total;
        longint unsigned ln;
        longint unsigned quot;
        longint unsigned ent;
        logic            sat;
        result_t         r;
        sat        = 1'b0;
        ent        = 0;
        prev_total = freq_total;
        old_f      = freq_hist[it.symbol];
        new_f      = old_f + it.count;
        if (new_f > FREQ_MAX)
        begin
            new_f = FREQ_MAX;
            sat   = 1'b1;
        end
        new_total = prev_total + it.count;
        if (new_total > FREQ_MAX)
        begin
            new_total = FREQ_MAX;
            sat       = 1'b1;
        end
        log_sum = log_sum - old_f * log2_fixed(old_f) + new_f * log2_fixed(new_f);
        freq_hist[it.symbol] = new_f;
        freq_total           = new_total;
        if (prev_total != 0 && new_total != 0)
        begin
            ln   = log2_fixed(new_total);
            quot = log_sum / new_total;
            ent  = (ln > quot) ? ln - quot : 0;
            if (ent > ENTROPY_TOP)
                ent = ENTROPY_TOP;
        end
        r.entropy  = ent[ENTROPY_W-1:0];
        r.overflow = sat;
        if (it.last_of_sequence)
            clear_histogram();
        return r;
    endfunction

    function automatic void clear_histogram();
        foreach (freq_hist[i])
            freq_hist[i] = 0;
        freq_total = 0;
        log_sum    = 0;
    endfunction

    initial
    begin
        clear_histogram();
        error_count  = 0;
        result_count = 0;
    end

    assign pending_count = expected_results.size();

    // Predict on each input beat and compare on each result beat.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_results.insert(expected_results.size(), entropy_after_item(item));
            if (result_valid && !result_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $error("result beat with no expectation waiting");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.entropy !== want.entropy)
                    begin
                        error_count++;
                        $error("entropy: expected %0d, actual %0d", want.entropy,
                               result.entropy);
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        error_count++;
                        $error("overflow: expected %0d, actual %0d", want.overflow,
                               result.overflow);
                    end
                end
            end
        end
    end
endmodule

// ----- bench/incremental_shannon_entropy_top_tb.sv -----
`timescale 1ns / 1ps

module incremental_shannon_entropy_top_tb;
    import ise_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      error_count;
    int      pending_count;
    int      result_count;
    int      send_idle_pct;
    int      stall_pct;
    int      hold_off_cycles;
    int      items_sent;
    int      sequences_done;

    incremental_shannon_entropy_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    incremental_shannon_entropy_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial
        clk = 1'b0;
    always
        #1 clk = ~clk;

    // Receiver stall: a long hold-off overrides the random stall rate.
    initial
    begin
        result_stall    = 1'b0;
        hold_off_cycles = 0;
    end
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            result_stall    <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one beat, with random idle cycles first, and wait for acceptance.
    // Valid stays high after acceptance so that the next beat can follow at once.
    task automatic send_beat(input logic [7:0] sym, input logic [15:0] cnt,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{symbol: sym, count: cnt, last_of_sequence: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (last)
            sequences_done++;
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // A random sequence: mostly small counts over a random alphabet of 2 to 256 symbols, some large.
    task automatic send_sequence(input int len);
        int          alphabet;
        logic [15:0] cnt;
        alphabet = $urandom_range(1, 255);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0:       cnt = 16'($urandom);
                1:       cnt = 16'hffff;
                2:       cnt = 16'd0;
                default: cnt = 16'($urandom_range(1, 300));
            endcase
            send_beat(8'($urandom_range(alphabet)), cnt, i == len - 1);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_items);
        int target;
        send_idle_pct = idle;
        stall_pct     = stall;
        target        = items_sent + n_items;
        while (items_sent < target)
            send_sequence($urandom_range(1, 30));
    endtask

    initial
    begin
        item_valid     = 1'b0;
        item           = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        items_sent     = 0;
        sequences_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone item, extremes of fields, zero counts.
        send_beat(8'd0, 16'd5, 1'b1);
        send_beat(8'd255, 16'd0, 1'b0);
        send_beat(8'd255, 16'd0, 1'b0);
        send_beat(8'd0, 16'hffff, 1'b0);
        send_beat(8'd255, 16'hffff, 1'b0);
        send_beat(8'haa, 16'h5555, 1'b0);
        send_beat(8'h55, 16'haaaa, 1'b1);
        send_beat(8'd7, 16'd1, 1'b0);
        send_beat(8'd7, 16'd1, 1'b0);
        send_beat(8'd8, 16'd1, 1'b1);
        // Full counts piling onto one symbol.
        for (int i = 0; i < 12; i++)
            send_beat(8'd3, 16'hffff, 1'b0);
        send_beat(8'd4, 16'd9, 1'b1);
        wait_drained();

        run_phase(0, 0, 200);
        // Long hold-off while the sender keeps offering beats.
        hold_off_cycles = 2000;
        run_phase(0, 0, 60);
        wait_drained();
        run_phase(85, 0, 200);
        run_phase(0, 85, 200);
        run_phase(15, 15, 200);
        run_phase($urandom_range(0, 50), $urandom_range(0, 50), 200);
        send_beat(8'd1, 16'd1, 1'b1);
        wait_drained();
        repeat (300) @(posedge clk);

        $display("Sent %0d beats in %0d sequences, %0d results checked across idle, stall",
                 items_sent, sequences_done, result_count);
        $display("and long hold-off phases.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ise_pkg.sv
hdl/incremental_shannon_entropy_top.sv
bench/incremental_shannon_entropy_checker.sv
bench/incremental_shannon_entropy_top_tb.sv
